// ===== rtl/apf_pkg.sv =====
// Shared constants and controller/datapath interface types for the articulation point finder.
`default_nettype none
package apf_pkg;
	localparam int VTX_W = 7;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;
	localparam logic [VTX_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [VTX_W-1:0] ROOT_VERTEX = 7'd1;
	localparam logic [1:0] ROOT_CUT_CHILDREN = 2'd2;
	localparam logic REQ_RUN = 1'b1;

	typedef struct packed {
		logic latch;
		logic add_rd_a;
		logic add_wr_a;
		logic add_rd_b;
		logic add_wr_b;
		logic set_ovf;
		logic run_init;
		logic root;
		logic edge_rd;
		logic tgt;
		logic disc;
		logic pop_rd;
		logic pop_apply;
		logic scan_step;
		logic emit_mid;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic req_run;
		logic add_ok;
		logic add_full;
		logic next_zero;
		logic sp_zero;
		logic scan_hit;
		logic scan_done;
		logic pend_vld;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/articulation_point_finder.sv =====
// Top level of the articulation point finder.
// Usage:
//   Input beats carry req_type, end_a, end_b. req_type 0 loads an undirected
//   edge (ignored if an endpoint is out of 1..MAX_VERTICES; dropped and
//   flagged once 2*MAX_EDGES entries are held). req_type 1 runs the
//   depth-first walk from vertex 1 and emits the cut vertices up to
//   node_count in ascending order, last one marked, or one none beat.
//   in_stall is high while any beat is in progress: a stored edge beat reads
//   and writes the heads of end_a and end_b, an ignored or dropped one only
//   checks. A run walks each adjacency entry, pops a frame per return to a
//   parent, then scans; the walk is bound by one read port per store.
//   Results sit in an output register; while out_stall is high the block
//   holds the beat and waits. The run ends with all stores cleared.
//   node_count is written with cfg_we/cfg_data; write it only while idle (not enforced).
//   Reset empties all stores and sets node_count to 64.
`default_nettype none
module articulation_point_finder #(
	parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = apf_pkg::MAX_EDGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [apf_pkg::VTX_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [apf_pkg::VTX_W-1:0] end_a,
	input  logic [apf_pkg::VTX_W-1:0] end_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [apf_pkg::VTX_W-1:0] cut_vertex,
	output logic                      is_last,
	output logic                      none_found,
	output logic                      edges_dropped
);
	import apf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	apf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	apf_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.end_a         (end_a),
		.end_b         (end_b),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.cut_vertex    (cut_vertex),
		.is_last       (is_last),
		.none_found    (none_found),
		.edges_dropped (edges_dropped),
		.cmd           (cmd),
		.sts           (sts)
	);

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_mid || cmd.emit_final) |-> sts.out_free)
		else $error("result emitted into a busy output register");
	a_mid_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_mid |-> sts.pend_vld)
		else $error("mid-run beat without a pending vertex");
	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && none_found) |-> (is_last && cut_vertex == '0))
		else $error("malformed none beat");
`endif
endmodule
`default_nettype wire

// ===== rtl/apf_ctrl.sv =====
// Sequencer for edge loading, depth-first walk and result scan.
`default_nettype none
module apf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  apf_pkg::sts_t sts,
	output apf_pkg::cmd_t cmd
);
	import apf_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_ADD_RA   = 13'b0000000000010,
		S_ADD_WA   = 13'b0000000000100,
		S_ADD_RB   = 13'b0000000001000,
		S_ADD_WB   = 13'b0000000010000,
		S_RUN_INIT = 13'b0000000100000,
		S_ROOT     = 13'b0000001000000,
		S_EDGE     = 13'b0000010000000,
		S_TGT      = 13'b0000100000000,
		S_DISC     = 13'b0001000000000,
		S_POP2     = 13'b0010000000000,
		S_SCAN     = 13'b0100000000000,
		S_FINAL    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = (sts.req_run == REQ_RUN) ? S_RUN_INIT : S_ADD_RA;
				end
			end
			S_ADD_RA: begin
				if (!sts.add_ok) begin
					state_d = S_IDLE;
				end else if (sts.add_full) begin
					cmd.set_ovf = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.add_rd_a = 1'b1;
					state_d = S_ADD_WA;
				end
			end
			S_ADD_WA: begin
				cmd.add_wr_a = 1'b1;
				state_d = S_ADD_RB;
			end
			S_ADD_RB: begin
				cmd.add_rd_b = 1'b1;
				state_d = S_ADD_WB;
			end
			S_ADD_WB: begin
				cmd.add_wr_b = 1'b1;
				state_d = S_IDLE;
			end
			S_RUN_INIT: begin
				cmd.run_init = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				state_d = S_EDGE;
			end
			S_EDGE: begin
				if (!sts.next_zero) begin
					cmd.edge_rd = 1'b1;
					state_d = S_TGT;
				end else if (sts.sp_zero) begin
					state_d = S_SCAN;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d = S_POP2;
				end
			end
			S_TGT: begin
				cmd.tgt = 1'b1;
				state_d = S_DISC;
			end
			S_DISC: begin
				cmd.disc = 1'b1;
				state_d = S_EDGE;
			end
			S_POP2: begin
				cmd.pop_apply = 1'b1;
				state_d = S_EDGE;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FINAL;
				end else if (sts.scan_hit && sts.pend_vld) begin
					if (sts.out_free) begin
						cmd.emit_mid = 1'b1;
						cmd.scan_step = 1'b1;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/apf_dp.sv =====
// Datapath: adjacency stores, discovery times, walk stack, cut marks and result register.
`default_nettype none
module apf_dp #(
	parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = apf_pkg::MAX_EDGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [apf_pkg::VTX_W-1:0] cfg_data,
	input  logic                      req_type,
	input  logic [apf_pkg::VTX_W-1:0] end_a,
	input  logic [apf_pkg::VTX_W-1:0] end_b,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [apf_pkg::VTX_W-1:0] cut_vertex,
	output logic                      is_last,
	output logic                      none_found,
	output logic                      edges_dropped,
	input  apf_pkg::cmd_t             cmd,
	output apf_pkg::sts_t             sts
);
	import apf_pkg::*;

	localparam int SLOTS = 2 * MAX_EDGES;
	localparam int EW    = $clog2(SLOTS + 1);
	localparam int EIW   = $clog2(SLOTS);
	localparam int VIW   = $clog2(MAX_VERTICES);
	localparam int SPW   = $clog2(MAX_VERTICES + 1);
	localparam logic [VTX_W-1:0] VMAX = VTX_W'(MAX_VERTICES);

	typedef struct packed {
		logic [VIW-1:0] tgt;
		logic [EW-1:0]  link;
	} edge_t;

	typedef struct packed {
		logic [VTX_W-1:0] v;
		logic [VTX_W-1:0] par;
		logic [EW-1:0]    nxt;
		logic [1:0]       kids;
		logic [VTX_W-1:0] disc;
		logic [VTX_W-1:0] low;
	} frame_t;

	edge_t  edge_mem [SLOTS];
	logic [EW-1:0] head_mem [MAX_VERTICES];
	logic [VTX_W-1:0] disc_mem [MAX_VERTICES];
	frame_t stk_mem [MAX_VERTICES];

	logic [VTX_W-1:0] node_count_q, a_q, b_q, clk_cnt_q, sv_q, pend_q, limit;
	logic [MAX_VERTICES-1:0] head_vld_q, disc_vld_q, cut_q;
	logic [EW-1:0] ec_q, head_rd_q, head_val, head_wd;
	logic head_rv_q, disc_rv_q, ovf_q, pend_vld_q;
	logic [VTX_W-1:0] disc_rd_q, t_vtx, new_time, pop_low;
	edge_t edge_rd_q;
	frame_t cur_q, stk_rd_q;
	logic [VIW-1:0] t_q, a_idx, b_idx, head_ra, head_wa, stk_ra;
	logic [SPW-1:0] sp_q;
	logic head_we, push;
	logic out_valid_q, is_last_q, none_found_q, edges_dropped_q;
	logic [VTX_W-1:0] cut_vertex_q;

	assign a_idx    = VIW'(a_q - 7'd1);
	assign b_idx    = VIW'(b_q - 7'd1);
	assign head_val = head_rv_q ? head_rd_q : '0;
	assign t_vtx    = VTX_W'(t_q) + 7'd1;
	assign new_time = clk_cnt_q + 7'd1;
	assign push     = cmd.disc && !disc_rv_q;
	assign stk_ra   = VIW'(sp_q - 1'b1);
	assign limit    = (node_count_q > VMAX) ? VMAX : node_count_q;
	assign pop_low  = (cur_q.low < stk_rd_q.low) ? cur_q.low : stk_rd_q.low;

	always_comb begin
		head_ra = '0;
		if (cmd.add_rd_a) head_ra = a_idx;
		else if (cmd.add_rd_b) head_ra = b_idx;
		else if (cmd.tgt) head_ra = edge_rd_q.tgt;
		head_we = cmd.add_wr_a || cmd.add_wr_b;
		head_wa = cmd.add_wr_a ? a_idx : b_idx;
		head_wd = ec_q + 1'b1;
	end

	always_comb begin
		sts.req_run   = req_type;
		sts.add_ok    = (a_q >= 7'd1) && (a_q <= VMAX) && (b_q >= 7'd1) && (b_q <= VMAX);
		sts.add_full  = (32'(ec_q) + 2) > SLOTS;
		sts.next_zero = (cur_q.nxt == '0);
		sts.sp_zero   = (sp_q == '0);
		sts.scan_done = (sv_q > limit);
		sts.scan_hit  = cut_q[VIW'(sv_q - 7'd1)];
		sts.pend_vld  = pend_vld_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// memories and payload
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
		if (cmd.add_wr_a) edge_mem[ec_q[EIW-1:0]] <= '{tgt: b_idx, link: head_val};
		if (cmd.add_wr_b) edge_mem[ec_q[EIW-1:0]] <= '{tgt: a_idx, link: head_val};
		if (cmd.edge_rd) edge_rd_q <= edge_mem[EIW'(cur_q.nxt - 1'b1)];
		if (cmd.root) disc_mem[0] <= ROOT_VERTEX;
		else if (push) disc_mem[t_q] <= new_time;
		disc_rd_q <= disc_mem[edge_rd_q.tgt];
		if (push) stk_mem[sp_q[VIW-1:0]] <= '{v: cur_q.v, par: cur_q.par, nxt: cur_q.nxt,
			kids: (cur_q.kids == 2'd3) ? 2'd3 : cur_q.kids + 2'd1,
			disc: cur_q.disc, low: cur_q.low};
		stk_rd_q <= stk_mem[stk_ra];
		if (cmd.latch) begin
			a_q <= end_a;
			b_q <= end_b;
		end
		if (cmd.tgt) t_q <= edge_rd_q.tgt;
		if (cmd.root) begin
			cur_q <= '{v: ROOT_VERTEX, par: ROOT_VERTEX, nxt: head_val, kids: 2'd0,
				disc: ROOT_VERTEX, low: ROOT_VERTEX};
		end else if (cmd.tgt) begin
			cur_q.nxt <= edge_rd_q.link;
		end else if (push) begin
			cur_q <= '{v: t_vtx, par: cur_q.v, nxt: head_val, kids: 2'd0,
				disc: new_time, low: new_time};
		end else if (cmd.disc) begin
			if (t_vtx != cur_q.par && disc_rd_q < cur_q.low) cur_q.low <= disc_rd_q;
		end else if (cmd.pop_apply) begin
			cur_q <= stk_rd_q;
			cur_q.low <= pop_low;
		end
		if (cmd.emit_mid) begin
			cut_vertex_q    <= pend_q;
			is_last_q       <= 1'b0;
			none_found_q    <= 1'b0;
			edges_dropped_q <= ovf_q;
		end else if (cmd.emit_final) begin
			cut_vertex_q    <= pend_vld_q ? pend_q : '0;
			is_last_q       <= 1'b1;
			none_found_q    <= !pend_vld_q;
			edges_dropped_q <= ovf_q;
		end
		if (cmd.scan_step && sts.scan_hit) pend_q <= sv_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			head_vld_q   <= '0;
			disc_vld_q   <= '0;
			cut_q        <= '0;
			head_rv_q    <= 1'b0;
			disc_rv_q    <= 1'b0;
			ec_q         <= '0;
			clk_cnt_q    <= '0;
			ovf_q        <= 1'b0;
			sp_q         <= '0;
			sv_q         <= 7'd1;
			pend_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) node_count_q <= cfg_data;
			head_rv_q <= head_vld_q[head_ra];
			disc_rv_q <= disc_vld_q[edge_rd_q.tgt];
			if (head_we) begin
				head_vld_q[head_wa] <= 1'b1;
				ec_q <= ec_q + 1'b1;
			end
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.run_init) begin
				sv_q <= 7'd1;
				pend_vld_q <= 1'b0;
			end
			if (cmd.root) begin
				clk_cnt_q <= ROOT_VERTEX;
				disc_vld_q[0] <= 1'b1;
			end
			if (push) begin
				clk_cnt_q <= new_time;
				disc_vld_q[t_q] <= 1'b1;
				sp_q <= sp_q + 1'b1;
			end
			if (cmd.pop_rd) sp_q <= sp_q - 1'b1;
			if (cmd.pop_apply) begin
				if (stk_rd_q.v != ROOT_VERTEX && cur_q.low >= stk_rd_q.disc)
					cut_q[VIW'(stk_rd_q.v - 7'd1)] <= 1'b1;
				if (stk_rd_q.v == ROOT_VERTEX && stk_rd_q.kids == ROOT_CUT_CHILDREN)
					cut_q[VIW'(stk_rd_q.v - 7'd1)] <= 1'b1;
			end
			if (cmd.scan_step) begin
				sv_q <= sv_q + 7'd1;
				if (sts.scan_hit) pend_vld_q <= 1'b1;
			end
			if (cmd.emit_mid || cmd.emit_final) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit_final) begin
				head_vld_q <= '0;
				disc_vld_q <= '0;
				cut_q      <= '0;
				ec_q       <= '0;
				clk_cnt_q  <= '0;
				ovf_q      <= 1'b0;
				sp_q       <= '0;
				pend_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cut_vertex    = cut_vertex_q;
	assign is_last       = is_last_q;
	assign none_found    = none_found_q;
	assign edges_dropped = edges_dropped_q;
endmodule
`default_nettype wire
